@@ design/mdc_pkg.sv @@
// shared types and constants of the multisynth divider calculator
package mdc_pkg;

  localparam logic [31:0] VCO_RESET     = 32'd2534400000;
  localparam logic [31:0] MIN_OUT_RESET = 32'd5000000;

  localparam logic [63:0] A_MIN      = 64'd8;
  localparam logic [63:0] A_MAX      = 64'd567;
  localparam logic [63:0] A_FOUR     = 64'd4;
  localparam logic [63:0] A_SIX      = 64'd6;
  localparam logic [63:0] FRAC_LIMIT = 64'h0000_0000_4000_0000;
  localparam logic [17:0] P1_OFFSET  = 18'd512;
  localparam logic [6:0]  BASE_REG   = 7'd53;
  localparam logic [6:0]  BASE_STEP  = 7'd11;
  localparam logic [5:0]  DIV_LAST   = 6'd63;

  localparam logic CFG_VCO = 1'b0;
  localparam logic CFG_MIN = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_RANGE   = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_TOOBIG  = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_NDIV, OP_DOUBLE, OP_DBLR, OP_ERR1, OP_ERR2, OP_ERR3,
    OP_GCD, OP_RDN, OP_RDD, OP_MULLO, OP_MULHI, OP_ADDHI, OP_SUM, OP_LDABC,
    OP_HALVE, OP_PDIV, OP_AMUL, OP_ACSUM, OP_LDACT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic div_start;
    logic gcd_start;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic gcd_done;
    logic sample;
    logic lt_min;
    logic r_lt_max;
    logic sum_bad;
    logic a_bad2;
    logic a_bad3;
    logic halve_more;
  } stat_t;

endpackage

@@ design/mdc_if.sv @@
// item and configuration channel interfaces
interface mdc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  output_select;
  logic [28:0] rate_integer;
  logic [31:0] rate_num;
  logic [31:0] rate_den;
  modport source (output valid, output_select, rate_integer, rate_num, rate_den,
                  input ready);
  modport sink (input valid, output_select, rate_integer, rate_num, rate_den,
                output ready);
endinterface

interface mdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [17:0] word_p1;
  logic [29:0] word_p2;
  logic [30:0] word_p3;
  logic [9:0]  divider_whole;
  logic [30:0] divider_frac_num;
  logic [30:0] divider_frac_den;
  logic [5:0]  output_divider;
  logic [6:0]  register_base;
  logic [31:0] actual_integer;
  logic [63:0] actual_num;
  logic [63:0] actual_den;
  modport source (output valid, status, word_p1, word_p2, word_p3, divider_whole,
                  divider_frac_num, divider_frac_den, output_divider, register_base,
                  actual_integer, actual_num, actual_den, input ready);
  modport sink (input valid, status, word_p1, word_p2, word_p3, divider_whole,
                divider_frac_num, divider_frac_den, output_divider, register_base,
                actual_integer, actual_num, actual_den, output ready);
endinterface

interface mdc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/mdc_div.sv @@
// iterative 64 by 64 bit restoring divider, one quotient bit per cycle
module mdc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [63:0] rem_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q;
  logic [63:0] quo_q, rem_q, dvs_q;
  logic [64:0] shifted;
  logic        ge;

  assign shifted = {rem_q, quo_q[63]};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == mdc_pkg::DIV_LAST) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(shifted - {1'b0, dvs_q}) : shifted[63:0];
      quo_q <= {quo_q[62:0], ge};
      cnt_q <= cnt_q + 6'd1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ design/mdc_gcd.sv @@
// binary gcd unit, one subtract or shift step per cycle
module mdc_gcd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] g_o
);

  logic        busy_q, done_q;
  logic [63:0] u_q, v_q, g_q;
  logic [6:0]  k_q;
  logic        fin;

  assign fin = (u_q == '0) || (v_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && fin) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= a_i;
      v_q <= b_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (fin) begin
        g_q <= (u_q | v_q) << k_q;
      end else if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1;
        v_q <= v_q >> 1;
        k_q <= k_q + 7'd1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= u_q - v_q;
      end else begin
        v_q <= v_q - u_q;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

@@ design/mdc_dp.sv @@
// datapath: working registers, shared multiplier, divider and gcd units
module mdc_dp #(
  parameter int MAX_OUTPUT_DIVIDER = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mdc_pkg::cmd_t      cmd_i,
  output mdc_pkg::stat_t     stat_o,
  input  logic [1:0]         output_select_i,
  input  logic [28:0]        rate_integer_i,
  input  logic [31:0]        rate_num_i,
  input  logic [31:0]        rate_den_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic [1:0]         status_o,
  output logic [17:0]        word_p1_o,
  output logic [29:0]        word_p2_o,
  output logic [30:0]        word_p3_o,
  output logic [9:0]         divider_whole_o,
  output logic [30:0]        divider_frac_num_o,
  output logic [30:0]        divider_frac_den_o,
  output logic [5:0]         output_divider_o,
  output logic [6:0]         register_base_o,
  output logic [31:0]        actual_integer_o,
  output logic [63:0]        actual_num_o,
  output logic [63:0]        actual_den_o
);

  logic [31:0] vco_q, min_q;
  mdc_pkg::status_e status_q;
  logic [63:0] whole_q, num_q, den_q, g_q, m_q, p_q;
  logic        ovf_q;
  logic [5:0]  r_q;
  logic [2:0]  rexp_q;
  logic [1:0]  sel_q;
  logic [9:0]  a_q;
  logic [30:0] b_q, c_q;
  logic [17:0] p1_q;
  logic [29:0] p2_q;

  logic        sample, ok;
  logic [64:0] n2, sum65;
  logic        dbl_ge;
  logic [63:0] dbl_num, dbl_whole;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [96:0] hi_sum;
  logic [63:0] div_a, div_b, div_quo, div_rem, gcd_g;
  logic        div_done, gcd_done;
  mdc_pkg::op_e op;

  assign op     = cmd_i.op;
  assign sample = (sel_q == 2'd1) || (sel_q == 2'd2);

  // doubling of whole + num/den with num kept below den
  assign n2        = {num_q, 1'b0};
  assign dbl_ge    = n2 >= {1'b0, den_q};
  assign dbl_num   = dbl_ge ? 64'(n2 - {1'b0, den_q}) : n2[63:0];
  assign dbl_whole = {whole_q[62:0], 1'b0} + {63'd0, dbl_ge};

  always_comb begin
    case (op)
      mdc_pkg::OP_MULLO: begin
        mul_a = whole_q[31:0];
        mul_b = den_q[31:0];
      end
      mdc_pkg::OP_MULHI: begin
        mul_a = whole_q[63:32];
        mul_b = den_q[31:0];
      end
      mdc_pkg::OP_SUM: begin
        mul_a = vco_q;
        mul_b = den_q[31:0];
      end
      mdc_pkg::OP_AMUL: begin
        mul_a = {22'd0, a_q};
        mul_b = {1'b0, c_q};
      end
      mdc_pkg::OP_ACSUM: begin
        mul_a = vco_q;
        mul_b = {1'b0, c_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign hi_sum = {33'd0, p_q} + {1'b0, m_q, 32'd0};
  assign sum65  = {1'b0, p_q} + {1'b0, num_q};

  always_comb begin
    case (op)
      mdc_pkg::OP_RDN: begin
        div_a = num_q;
        div_b = g_q;
      end
      mdc_pkg::OP_RDD: begin
        div_a = den_q;
        div_b = g_q;
      end
      mdc_pkg::OP_PDIV: begin
        div_a = {num_q[56:0], 7'd0};
        div_b = den_q;
      end
      default: begin
        div_a = num_q;
        div_b = den_q;
      end
    endcase
  end

  mdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  mdc_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.gcd_start),
    .a_i     (num_q),
    .b_i     (den_q),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  always_comb begin
    stat_o.div_done   = div_done;
    stat_o.gcd_done   = gcd_done;
    stat_o.sample     = sample;
    stat_o.lt_min     = whole_q < {32'd0, min_q};
    stat_o.r_lt_max   = {1'b0, r_q} < 7'(MAX_OUTPUT_DIVIDER);
    stat_o.sum_bad    = ovf_q || sum65[64] || (sum65[63:0] == '0);
    stat_o.a_bad2     = (whole_q < mdc_pkg::A_MIN) && (whole_q != mdc_pkg::A_FOUR) &&
                        (whole_q != mdc_pkg::A_SIX);
    stat_o.a_bad3     = whole_q > mdc_pkg::A_MAX;
    stat_o.halve_more = (num_q > mdc_pkg::FRAC_LIMIT) || (den_q > mdc_pkg::FRAC_LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vco_q    <= mdc_pkg::VCO_RESET;
      min_q    <= mdc_pkg::MIN_OUT_RESET;
      status_q <= mdc_pkg::STAT_OK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mdc_pkg::CFG_VCO: vco_q <= cfg_data_i;
          mdc_pkg::CFG_MIN: min_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (op)
        mdc_pkg::OP_LOAD: status_q <= mdc_pkg::STAT_OK;
        mdc_pkg::OP_ERR1: status_q <= mdc_pkg::STAT_RANGE;
        mdc_pkg::OP_ERR2: status_q <= mdc_pkg::STAT_INVALID;
        mdc_pkg::OP_ERR3: status_q <= mdc_pkg::STAT_TOOBIG;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      mdc_pkg::OP_LOAD: begin
        whole_q <= {35'd0, rate_integer_i};
        if (rate_den_i == '0) begin
          num_q <= '0;
          den_q <= 64'd1;
        end else begin
          num_q <= {32'd0, rate_num_i};
          den_q <= {32'd0, rate_den_i};
        end
        r_q    <= 6'd1;
        rexp_q <= '0;
        sel_q  <= output_select_i;
        ovf_q  <= 1'b0;
      end
      mdc_pkg::OP_NDIV: begin
        if (div_done) begin
          whole_q <= whole_q + div_quo;
          num_q   <= div_rem;
        end
      end
      mdc_pkg::OP_DOUBLE: begin
        whole_q <= dbl_whole;
        num_q   <= dbl_num;
      end
      mdc_pkg::OP_DBLR: begin
        whole_q <= dbl_whole;
        num_q   <= dbl_num;
        r_q     <= {r_q[4:0], 1'b0};
        rexp_q  <= rexp_q + 3'd1;
      end
      mdc_pkg::OP_GCD: begin
        if (gcd_done) begin
          g_q <= gcd_g;
        end
      end
      mdc_pkg::OP_RDN: begin
        if (div_done) begin
          num_q <= div_quo;
        end
      end
      mdc_pkg::OP_RDD: begin
        if (div_done) begin
          den_q <= div_quo;
        end
      end
      mdc_pkg::OP_MULLO: m_q <= mul_p;
      mdc_pkg::OP_MULHI: begin
        p_q <= m_q;
        m_q <= mul_p;
      end
      mdc_pkg::OP_ADDHI: begin
        p_q   <= hi_sum[63:0];
        ovf_q <= |hi_sum[96:64];
      end
      mdc_pkg::OP_SUM: begin
        p_q <= sum65[63:0];
        m_q <= mul_p;
      end
      mdc_pkg::OP_LDABC: begin
        num_q   <= m_q;
        den_q   <= p_q;
        whole_q <= '0;
      end
      mdc_pkg::OP_HALVE: begin
        num_q <= num_q >> 1;
        den_q <= den_q >> 1;
      end
      mdc_pkg::OP_PDIV: begin
        if (div_done) begin
          p1_q <= 18'({1'b0, whole_q[9:0], 7'd0}) + div_quo[17:0] - mdc_pkg::P1_OFFSET;
          p2_q <= div_rem[29:0];
          a_q  <= whole_q[9:0];
          b_q  <= num_q[30:0];
          c_q  <= den_q[30:0];
        end
      end
      mdc_pkg::OP_AMUL: m_q <= mul_p;
      mdc_pkg::OP_ACSUM: begin
        p_q <= m_q + {33'd0, b_q};
        m_q <= mul_p;
      end
      mdc_pkg::OP_LDACT: begin
        num_q   <= m_q;
        den_q   <= (p_q << rexp_q) << sample;
        whole_q <= '0;
      end
      default: ;
    endcase
  end

  // error results carry only status and register base
  assign ok                 = status_q == mdc_pkg::STAT_OK;
  assign status_o           = status_q;
  assign word_p1_o          = ok ? p1_q : '0;
  assign word_p2_o          = ok ? p2_q : '0;
  assign word_p3_o          = ok ? c_q : '0;
  assign divider_whole_o    = ok ? a_q : '0;
  assign divider_frac_num_o = ok ? b_q : '0;
  assign divider_frac_den_o = ok ? c_q : '0;
  assign output_divider_o   = ok ? r_q : '0;
  assign register_base_o    = mdc_pkg::BASE_REG + 7'(mdc_pkg::BASE_STEP * {5'd0, sel_q});
  assign actual_integer_o   = ok ? whole_q[31:0] : '0;
  assign actual_num_o       = ok ? num_q : '0;
  assign actual_den_o       = ok ? den_q : '0;

endmodule

@@ design/mdc_ctrl.sv @@
// controller: sequences the datapath steps for one item
module mdc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  mdc_pkg::stat_t stat_i,
  output mdc_pkg::cmd_t  cmd_o
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1,
    S_NDIV  = 19'd2,
    S_DBL   = 19'd4,
    S_LOOP  = 19'd8,
    S_GCD   = 19'd16,
    S_RDN   = 19'd32,
    S_RDD   = 19'd64,
    S_MULLO = 19'd128,
    S_MULHI = 19'd256,
    S_ADDHI = 19'd512,
    S_SUM   = 19'd1024,
    S_LDABC = 19'd2048,
    S_ACHK  = 19'd4096,
    S_HALVE = 19'd8192,
    S_PDIV  = 19'd16384,
    S_AMUL  = 19'd32768,
    S_ACSUM = 19'd65536,
    S_LDACT = 19'd131072,
    S_DONE  = 19'd262144
  } state_e;

  typedef enum logic [1:0] {
    PH_REQ = 2'd0,
    PH_ABC = 2'd1,
    PH_ACT = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   issued_q, issued_d;

  always_comb begin
    state_d         = state_q;
    phase_d         = phase_q;
    issued_d        = issued_q;
    cmd_o.op        = mdc_pkg::OP_NONE;
    cmd_o.div_start = 1'b0;
    cmd_o.gcd_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = mdc_pkg::OP_LOAD;
          phase_d  = PH_REQ;
          state_d  = S_NDIV;
        end
      end
      S_NDIV: begin
        cmd_o.op = mdc_pkg::OP_NDIV;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (stat_i.div_done) begin
          issued_d = 1'b0;
          case (phase_q)
            PH_REQ:  state_d = S_DBL;
            PH_ABC:  state_d = S_ACHK;
            default: state_d = S_GCD;
          endcase
        end
      end
      S_DBL: begin
        if (stat_i.sample) begin
          cmd_o.op = mdc_pkg::OP_DOUBLE;
        end
        state_d = S_LOOP;
      end
      S_LOOP: begin
        if (stat_i.lt_min && stat_i.r_lt_max) begin
          cmd_o.op = mdc_pkg::OP_DBLR;
        end else if (stat_i.lt_min) begin
          cmd_o.op = mdc_pkg::OP_ERR1;
          state_d  = S_DONE;
        end else begin
          state_d = S_GCD;
        end
      end
      S_GCD: begin
        cmd_o.op = mdc_pkg::OP_GCD;
        if (!issued_q) begin
          cmd_o.gcd_start = 1'b1;
          issued_d        = 1'b1;
        end else if (stat_i.gcd_done) begin
          issued_d = 1'b0;
          state_d  = S_RDN;
        end
      end
      S_RDN: begin
        cmd_o.op = mdc_pkg::OP_RDN;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (stat_i.div_done) begin
          issued_d = 1'b0;
          state_d  = S_RDD;
        end
      end
      S_RDD: begin
        cmd_o.op = mdc_pkg::OP_RDD;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (stat_i.div_done) begin
          issued_d = 1'b0;
          case (phase_q)
            PH_REQ:  state_d = S_MULLO;
            PH_ABC:  state_d = S_HALVE;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_MULLO: begin
        cmd_o.op = mdc_pkg::OP_MULLO;
        state_d  = S_MULHI;
      end
      S_MULHI: begin
        cmd_o.op = mdc_pkg::OP_MULHI;
        state_d  = S_ADDHI;
      end
      S_ADDHI: begin
        cmd_o.op = mdc_pkg::OP_ADDHI;
        state_d  = S_SUM;
      end
      S_SUM: begin
        if (stat_i.sum_bad) begin
          cmd_o.op = mdc_pkg::OP_ERR2;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = mdc_pkg::OP_SUM;
          state_d  = S_LDABC;
        end
      end
      S_LDABC: begin
        cmd_o.op = mdc_pkg::OP_LDABC;
        phase_d  = PH_ABC;
        state_d  = S_NDIV;
      end
      S_ACHK: begin
        if (stat_i.a_bad2) begin
          cmd_o.op = mdc_pkg::OP_ERR2;
          state_d  = S_DONE;
        end else if (stat_i.a_bad3) begin
          cmd_o.op = mdc_pkg::OP_ERR3;
          state_d  = S_DONE;
        end else begin
          state_d = S_GCD;
        end
      end
      S_HALVE: begin
        if (stat_i.halve_more) begin
          cmd_o.op = mdc_pkg::OP_HALVE;
        end else begin
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd_o.op = mdc_pkg::OP_PDIV;
        if (!issued_q) begin
          cmd_o.div_start = 1'b1;
          issued_d        = 1'b1;
        end else if (stat_i.div_done) begin
          issued_d = 1'b0;
          state_d  = S_AMUL;
        end
      end
      S_AMUL: begin
        cmd_o.op = mdc_pkg::OP_AMUL;
        state_d  = S_ACSUM;
      end
      S_ACSUM: begin
        cmd_o.op = mdc_pkg::OP_ACSUM;
        state_d  = S_LDACT;
      end
      S_LDACT: begin
        cmd_o.op = mdc_pkg::OP_LDACT;
        phase_d  = PH_ACT;
        state_d  = S_NDIV;
      end
      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_REQ;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      issued_q <= issued_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_DONE;

endmodule

@@ design/multisynth_divider_calculator_unit.sv @@
// top level of the multisynth divider calculator
// usage:
//   in_i carries one request item: output select, whole hertz and a fraction.
//   out_o returns one result item per request: status, P1/P2/P3 words, a, b, c,
//   R, register base and the achieved frequency as a reduced fraction.
//   cfg_i writes the VCO frequency (index 0) or the minimum multisynth rate
//   (index 1); writes are always taken and belong between items.
// timing:
//   one item at a time; in_i.ready is high only while no item is in work.
//   an item makes up to ten passes through the shared 64-step divider and up to
//   three binary gcd runs; error results return earlier.
//   the result stays on out_o until taken; while the receiver stalls no new
//   item is accepted.
// reset:
//   returns to idle and loads the default VCO and minimum rate registers.
module multisynth_divider_calculator_unit #(
  parameter int MAX_OUTPUT_DIVIDER = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  mdc_in_if.sink     in_i,
  mdc_out_if.source  out_o,
  mdc_cfg_if.sink    cfg_i
);

  mdc_pkg::cmd_t  cmd;
  mdc_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;

  mdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mdc_dp #(
    .MAX_OUTPUT_DIVIDER (MAX_OUTPUT_DIVIDER)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .output_select_i    (in_i.output_select),
    .rate_integer_i     (in_i.rate_integer),
    .rate_num_i         (in_i.rate_num),
    .rate_den_i         (in_i.rate_den),
    .cfg_we_i           (cfg_i.valid && cfg_i.ready),
    .cfg_index_i        (cfg_i.index),
    .cfg_data_i         (cfg_i.data),
    .status_o           (out_o.status),
    .word_p1_o          (out_o.word_p1),
    .word_p2_o          (out_o.word_p2),
    .word_p3_o          (out_o.word_p3),
    .divider_whole_o    (out_o.divider_whole),
    .divider_frac_num_o (out_o.divider_frac_num),
    .divider_frac_den_o (out_o.divider_frac_den),
    .output_divider_o   (out_o.output_divider),
    .register_base_o    (out_o.register_base),
    .actual_integer_o   (out_o.actual_integer),
    .actual_num_o       (out_o.actual_num),
    .actual_den_o       (out_o.actual_den)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_o.valid && in_i.ready))
    else $error("result pending while input is ready");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  a_ok_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == mdc_pkg::STAT_OK |->
      out_o.divider_whole >= 10'd4 && out_o.divider_whole <= 10'd567 &&
      $onehot(out_o.output_divider))
    else $error("ok result with divider out of range");

endmodule

@@ verif/multisynth_divider_calculator_checker.sv @@
// checker that predicts and compares every result item of the divider calculator
`timescale 1ns / 1ps
module multisynth_divider_calculator_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mdc_in_if    in_ch,
  mdc_out_if   out_ch,
  mdc_cfg_if   cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [63:0] RATIO_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIV_LIMIT = 64'd32;
  localparam logic [63:0] P_SCALE   = 64'd128;

  typedef struct packed {
    mdc_pkg::status_e status;
    logic [17:0] word_p1;
    logic [29:0] word_p2;
    logic [30:0] word_p3;
    logic [9:0]  divider_whole;
    logic [30:0] divider_frac_num;
    logic [30:0] divider_frac_den;
    logic [5:0]  output_divider;
    logic [6:0]  register_base;
    logic [31:0] actual_integer;
    logic [63:0] actual_num;
    logic [63:0] actual_den;
  } divider_result_t;

  divider_result_t settings_q[$];
  logic [63:0] vco_hz;
  logic [63:0] min_rate_hz;

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = y;
      y = x % t;
      x = t;
    end
    return x;
  endfunction

  function automatic void reduce(inout logic [63:0] w, inout logic [63:0] n,
                                 inout logic [63:0] d);
    logic [63:0] q;
    logic [63:0] g;
    if (d > 0 && n >= d) begin
      q = n / d;
      w = w + q;
      n = n - q * d;
    end
    g = gcd_of(n, d);
    if (g > 0) begin
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic void double_rate(inout logic [63:0] w, inout logic [63:0] n,
                                      inout logic [63:0] d);
    w = w * 2;
    n = n * 2;
    reduce(w, n, d);
  endfunction

  function automatic divider_result_t compute_settings(logic [1:0] sel, logic [28:0] whole,
                                                       logic [31:0] num, logic [31:0] den);
    divider_result_t res;
    logic sample;
    logic [63:0] w, n, d, r, prod, aw, an, ad, a, b, c, xw, xn, xd;
    res = '0;
    res.status = mdc_pkg::STAT_OK;
    res.register_base = mdc_pkg::BASE_REG + mdc_pkg::BASE_STEP * {5'd0, sel};
    sample = (sel == 2'd1 || sel == 2'd2);
    w = {35'd0, whole};
    n = {32'd0, num};
    d = {32'd0, den};
    if (d == 0) begin
      n = 0;
      d = 1;
    end
    reduce(w, n, d);
    if (sample) double_rate(w, n, d);
    r = 1;
    while (w < min_rate_hz && r < DIV_LIMIT) begin
      double_rate(w, n, d);
      r = r << 1;
    end
    if (r >= DIV_LIMIT && w < min_rate_hz) begin
      res.status = mdc_pkg::STAT_RANGE;
      return res;
    end
    if (w != 0 && w > RATIO_MAX / d) begin
      res.status = mdc_pkg::STAT_INVALID;
      return res;
    end
    prod = w * d;
    if (prod > RATIO_MAX - n) begin
      res.status = mdc_pkg::STAT_INVALID;
      return res;
    end
    aw = 0;
    an = vco_hz * d;
    ad = prod + n;
    if (ad == 0) begin
      res.status = mdc_pkg::STAT_INVALID;
      return res;
    end
    reduce(aw, an, ad);
    a = aw;
    if (a < mdc_pkg::A_MIN) begin
      if (a != mdc_pkg::A_FOUR && a != mdc_pkg::A_SIX) begin
        res.status = mdc_pkg::STAT_INVALID;
        return res;
      end
    end else if (a > mdc_pkg::A_MAX) begin
      res.status = mdc_pkg::STAT_TOOBIG;
      return res;
    end
    b = an;
    c = ad;
    while (b > mdc_pkg::FRAC_LIMIT || c > mdc_pkg::FRAC_LIMIT) begin
      b = b >> 1;
      c = c >> 1;
    end
    if (c == 0) c = 1;
    xw = 0;
    xn = vco_hz * c;
    xd = r * (a * c + b);
    if (sample) xd = xd * 2;
    reduce(xw, xn, xd);
    res.word_p1 = 18'((a * c + b) * P_SCALE / c - 64'(mdc_pkg::P1_OFFSET));
    res.word_p2 = 30'((b * P_SCALE) % c);
    res.word_p3 = 31'(c);
    res.divider_whole = 10'(a);
    res.divider_frac_num = 31'(b);
    res.divider_frac_den = 31'(c);
    res.output_divider = 6'(r);
    res.actual_integer = 32'(xw);
    res.actual_num = xn;
    res.actual_den = xd;
    return res;
  endfunction

  assign pending_o = settings_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    divider_result_t want;
    int errs;
    if (!rst_ni) begin
      vco_hz <= {32'd0, mdc_pkg::VCO_RESET};
      min_rate_hz <= {32'd0, mdc_pkg::MIN_OUT_RESET};
      fail_count_o <= 0;
      settings_q.delete();
    end else begin
      errs = 0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == mdc_pkg::CFG_VCO) vco_hz <= {32'd0, cfg_ch.data};
        else min_rate_hz <= {32'd0, cfg_ch.data};
      end
      if (in_ch.valid && in_ch.ready)
        settings_q.push_back(compute_settings(in_ch.output_select, in_ch.rate_integer,
                                              in_ch.rate_num, in_ch.rate_den));
      if (out_ch.valid && out_ch.ready) begin
        if (settings_q.size() == 0) begin
          $error("result item with none expected");
          errs++;
        end else begin
          want = settings_q.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_ch.status);
            errs++;
          end
          if (out_ch.word_p1 !== want.word_p1) begin
            $error("word_p1: expected %0d actual %0d", want.word_p1, out_ch.word_p1);
            errs++;
          end
          if (out_ch.word_p2 !== want.word_p2) begin
            $error("word_p2: expected %0d actual %0d", want.word_p2, out_ch.word_p2);
            errs++;
          end
          if (out_ch.word_p3 !== want.word_p3) begin
            $error("word_p3: expected %0d actual %0d", want.word_p3, out_ch.word_p3);
            errs++;
          end
          if (out_ch.divider_whole !== want.divider_whole) begin
            $error("divider_whole: expected %0d actual %0d", want.divider_whole,
                   out_ch.divider_whole);
            errs++;
          end
          if (out_ch.divider_frac_num !== want.divider_frac_num) begin
            $error("divider_frac_num: expected %0d actual %0d", want.divider_frac_num,
                   out_ch.divider_frac_num);
            errs++;
          end
          if (out_ch.divider_frac_den !== want.divider_frac_den) begin
            $error("divider_frac_den: expected %0d actual %0d", want.divider_frac_den,
                   out_ch.divider_frac_den);
            errs++;
          end
          if (out_ch.output_divider !== want.output_divider) begin
            $error("output_divider: expected %0d actual %0d", want.output_divider,
                   out_ch.output_divider);
            errs++;
          end
          if (out_ch.register_base !== want.register_base) begin
            $error("register_base: expected %0d actual %0d", want.register_base,
                   out_ch.register_base);
            errs++;
          end
          if (out_ch.actual_integer !== want.actual_integer) begin
            $error("actual_integer: expected %0d actual %0d", want.actual_integer,
                   out_ch.actual_integer);
            errs++;
          end
          if (out_ch.actual_num !== want.actual_num) begin
            $error("actual_num: expected %0d actual %0d", want.actual_num,
                   out_ch.actual_num);
            errs++;
          end
          if (out_ch.actual_den !== want.actual_den) begin
            $error("actual_den: expected %0d actual %0d", want.actual_den,
                   out_ch.actual_den);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

@@ verif/multisynth_divider_calculator_unit_tb.sv @@
// stimulus, configuration phases and verdict for the divider calculator
`timescale 1ns / 1ps
module multisynth_divider_calculator_unit_tb;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 1600;
  localparam int RANDOM_PER_SET = 80;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   idle_cycles;
  int   results_seen;
  logic hold_off_done;
  logic [31:0] vco_now;

  mdc_in_if  in_ch ();
  mdc_out_if out_ch ();
  mdc_cfg_if cfg_ch ();

  multisynth_divider_calculator_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  multisynth_divider_calculator_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  task automatic send_request(logic [1:0] sel, logic [28:0] whole, logic [31:0] num,
                              logic [31:0] den);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.output_select <= sel;
    in_ch.rate_integer <= whole;
    in_ch.rate_num <= num;
    in_ch.rate_den <= den;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_register(logic index, logic [31:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (index == mdc_pkg::CFG_VCO) vco_now = value;
  endtask

  task automatic send_random_request();
    int kind;
    int mult;
    int a_goal;
    logic [1:0] sel;
    logic [63:0] whole;
    kind = $urandom_range(0, 9);
    sel = 2'($urandom_range(0, 3));
    if (kind < 6) begin
      // aim at a usable divider with random fraction
      a_goal = $urandom_range(3, 600);
      mult = 1 << $urandom_range(0, 6);
      if (sel == 2'd1 || sel == 2'd2) mult = mult * 2;
      whole = {32'd0, vco_now} / (a_goal * mult);
      if (whole > 64'd536870911) whole = 64'd536870911;
      send_request(sel, 29'(whole), $urandom_range(0, 999), $urandom_range(1, 1000));
    end else if (kind < 8) begin
      send_request(sel, 29'($urandom), $urandom, $urandom);
    end else begin
      send_request(sel, 29'($urandom_range(0, 2000)), $urandom_range(0, 50),
                   $urandom_range(0, 50));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stall;
    int pick;
    stall = 0;
    hold_off_done = 1'b0;
    results_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) results_seen++;
      if (!hold_off_done && results_seen == 60) begin
        // long hold-off while the sender keeps offering items
        hold_off_done = 1'b1;
        stall = 3000;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        pick = $urandom_range(0, 19);
        if (pick < 3) stall = $urandom_range(1, 3);
        else if (pick == 3) stall = $urandom_range(20, 300);
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.output_select <= '0;
    in_ch.rate_integer <= '0;
    in_ch.rate_num <= '0;
    in_ch.rate_den <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= mdc_pkg::CFG_VCO;
    cfg_ch.data <= '0;
    vco_now = mdc_pkg::VCO_RESET;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(2'd0, 29'd50000000, 32'd0, 32'd1);
    send_request(2'd1, 29'd61440000, 32'd1, 32'd3);
    send_request(2'd2, 29'd30720000, 32'd7, 32'd9);
    send_request(2'd3, 29'd38400000, 32'd0, 32'd1);
    send_request(2'd3, 29'd0, 32'd0, 32'd1);
    send_request(2'd3, 29'h1FFFFFFF, 32'd0, 32'd1);
    send_request(2'd3, 29'h1FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_request(2'd3, 29'd10000000, 32'hFFFFFFFF, 32'd1);
    send_request(2'd3, 29'd10000000, 32'd5, 32'd0);
    send_request(2'd3, 29'd10000000, 32'd0, 32'hFFFFFFFF);
    send_request(2'd3, 29'd10000000, 32'd1, 32'hFFFFFFFF);
    send_request(2'd1, 29'd316800000, 32'd0, 32'd1);
    send_request(2'd1, 29'd211200000, 32'd0, 32'd1);
    send_request(2'd1, 29'd253440000, 32'd0, 32'd1);
    send_request(2'd3, 29'd362057142, 32'd6, 32'd7);
    send_request(2'd3, 29'd100000, 32'd0, 32'd1);
    send_request(2'd3, 29'd4470000, 32'd0, 32'd1);
    send_request(2'd0, 29'd1, 32'd1, 32'd2);
    send_request(2'd2, 29'd9999999, 32'd999, 32'd1000);
    send_request(2'd3, 29'd5000000, 32'h80000000, 32'hFFFFFFFE);
    repeat (RANDOM_PER_SET) send_random_request();

    write_register(mdc_pkg::CFG_VCO, 32'hFFFFFFFF);
    write_register(mdc_pkg::CFG_MIN, 32'd1);
    send_request(2'd3, 29'd1, 32'd0, 32'd1);
    send_request(2'd0, 29'h1FFFFFFF, 32'hFFFFFFFF, 32'd3);
    repeat (RANDOM_PER_SET) send_random_request();

    write_register(mdc_pkg::CFG_VCO, 32'd1);
    write_register(mdc_pkg::CFG_MIN, 32'hFFFFFFFF);
    repeat (RANDOM_PER_SET / 4) send_random_request();

    write_register(mdc_pkg::CFG_VCO, 32'($urandom_range(1000000000, 32'hF0000000)));
    write_register(mdc_pkg::CFG_MIN, 32'($urandom_range(1000000, 20000000)));
    repeat (RANDOM_PER_SET) send_random_request();

    write_register(mdc_pkg::CFG_VCO, 32'd0);
    send_request(2'd3, 29'd10000000, 32'd0, 32'd1);
    write_register(mdc_pkg::CFG_VCO, mdc_pkg::VCO_RESET);
    write_register(mdc_pkg::CFG_MIN, mdc_pkg::MIN_OUT_RESET);
    repeat (RANDOM_PER_SET + RANDOM_PER_SET / 2) send_random_request();

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
